// ===== rtl/core/ams_pkg.sv =====
package ams_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_DCHK,
    ST_DDIV,
    ST_DACC,
    ST_EXEC,
    ST_OPRD,
    ST_PRINT,
    ST_MUL,
    ST_DIV,
    ST_DFIN
  } state_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_STEP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_IDLE    = 3'd0,
    STAT_RUN     = 3'd1,
    STAT_HALT    = 3'd2,
    STAT_DEBUG   = 3'd3,
    STAT_DIVZERO = 3'd4,
    STAT_BADADDR = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_NUM  = 2'd1,
    KIND_CHAR = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  // instruction codes
  localparam int unsigned OPC_READ   = 10;
  localparam int unsigned OPC_WRITE  = 11;
  localparam int unsigned OPC_PRINT  = 12;
  localparam int unsigned OPC_LOAD   = 20;
  localparam int unsigned OPC_STORE  = 21;
  localparam int unsigned OPC_ADD    = 30;
  localparam int unsigned OPC_SUB    = 31;
  localparam int unsigned OPC_DIV    = 32;
  localparam int unsigned OPC_MUL    = 33;
  localparam int unsigned OPC_MOD    = 34;
  localparam int unsigned OPC_BRANCH = 40;
  localparam int unsigned OPC_BRNEG  = 41;
  localparam int unsigned OPC_BRZERO = 42;
  localparam int unsigned OPC_HALT   = 43;
  localparam int unsigned OPC_DEBUG  = 60;

  localparam int unsigned OP_LIMIT   = 100;
  localparam int unsigned CHUNK_BITS = 8;

endpackage

// ===== rtl/core/ams_ram.sv =====
module ams_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/accumulator_machine_step.sv =====
// Decimal accumulator machine with a word memory held in one synchronous RAM.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; opcode_i selects write word, read word, start run or execute
// one instruction. Every transaction gives exactly one result, shown for one
// cycle with done_o high; the receiver cannot stall, so results are never held.
// States passed between a transaction and its registered result:
//   write word, start run, step while not running: none beyond ST_IDLE
//   read word: ST_READ
//   step: ST_FETCH, then per decimal digit stripped from the instruction word
//     ST_DCHK, ST_DDIV (one 8-bit slice of the divide by ten per cycle) and
//     ST_DACC, a last ST_DCHK when a digit was stripped, then ST_EXEC; an
//     operand read adds ST_OPRD, print ST_PRINT, multiply ST_MUL, and a
//     nonzero divide or modulo ST_DIV and ST_DFIN.
// Multiply and divide use a serial shift and add unit, and digits are stripped
// from the instruction word by a serial divide by ten.
// One transaction is in work at a time; busy is high until its result.
// Reset: state, status, pc and acc clear at once, then a clearing pass writes
// zero to all MEM_WORDS words, one per cycle, with busy high throughout.
module accumulator_machine_step #(
  parameter int MEM_WORDS = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [9:0]  addr_i,
  input  logic [31:0] data_i,
  input  logic [31:0] read_value_i,
  output logic        done_o,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_value_o,
  output logic [2:0]  status_o,
  output logic [9:0]  pc_o,
  output logic [31:0] acc_value_o,
  output logic [31:0] decoded_op_o,
  output logic        read_used_o
);
  import ams_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int W  = WORD_BITS;
  localparam int CH = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int DW = CH * CHUNK_BITS;
  localparam int CW = $clog2(WORD_BITS);

  state_e          state_q, state_d;
  status_e         status_q, status_d;
  logic [AW-1:0]   pc_q, pc_d, clr_q, clr_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [31:0]     dec_q, dec_d;
  logic [W-1:0]    u_q, u_d, x_q, x_d, opnd_q, opnd_d, op_q, op_d;
  logic [DW-1:0]   dv_q, dv_d;
  logic [3:0]      rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [W-1:0]    ar_a_q, ar_a_d, ar_b_q, ar_b_d;
  logic [W:0]      ar_r_q, ar_r_d;
  logic            negq_q, negq_d, negr_q, negr_d;
  logic            addr_ok_q, addr_ok_d;
  logic [31:0]     rv_q, rv_d;
  logic            done_q, done_d;
  kind_e           kind_q, kind_d;
  logic [31:0]     val_q, val_d;
  logic            used_q, used_d;

  logic            accept;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [W-1:0]    mem_wdata, mem_rdata;
  logic [AW-1:0]   pc_inc;

  function automatic logic in_mem(input logic [63:0] v);
    return v < 64'(MEM_WORDS);
  endfunction

  function automatic logic is_op(input logic [W-1:0] op, input int unsigned code);
    return op == W'(code);
  endfunction

  function automatic logic uses_operand(input logic [W-1:0] op);
    return is_op(op, OPC_READ) || is_op(op, OPC_WRITE) || is_op(op, OPC_PRINT) ||
           is_op(op, OPC_LOAD) || is_op(op, OPC_STORE) || is_op(op, OPC_ADD) ||
           is_op(op, OPC_SUB) || is_op(op, OPC_DIV) || is_op(op, OPC_MUL) ||
           is_op(op, OPC_MOD) || is_op(op, OPC_BRANCH) || is_op(op, OPC_BRNEG) ||
           is_op(op, OPC_BRZERO);
  endfunction

  function automatic logic reads_operand(input logic [W-1:0] op);
    return is_op(op, OPC_WRITE) || is_op(op, OPC_PRINT) || is_op(op, OPC_LOAD) ||
           is_op(op, OPC_ADD) || is_op(op, OPC_SUB) || is_op(op, OPC_DIV) ||
           is_op(op, OPC_MUL) || is_op(op, OPC_MOD);
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign pc_inc = (pc_q == AW'(MEM_WORDS - 1)) ? '0 : pc_q + 1'b1;

  ams_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(MEM_WORDS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == CMD_READ) begin
            state_d = ST_READ;
          end else if (opcode_i == CMD_STEP && status_q == STAT_RUN) begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_FETCH: state_d = ($signed(mem_rdata) > $signed(W'(OP_LIMIT))) ? ST_DCHK : ST_EXEC;
      ST_DCHK:  state_d = (u_q > W'(OP_LIMIT)) ? ST_DDIV : ST_EXEC;
      ST_DDIV:  if (cnt_q == CW'(CH - 1)) state_d = ST_DACC;
      ST_DACC:  state_d = ST_DCHK;
      ST_EXEC: begin
        if (uses_operand(op_q) && !in_mem(64'(opnd_q))) begin
          state_d = ST_IDLE;
        end else if (reads_operand(op_q)) begin
          state_d = ST_OPRD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OPRD: begin
        priority if (is_op(op_q, OPC_PRINT)) begin
          state_d = in_mem(64'(mem_rdata)) ? ST_PRINT : ST_IDLE;
        end else if (is_op(op_q, OPC_MUL)) begin
          state_d = ST_MUL;
        end else if (is_op(op_q, OPC_DIV) || is_op(op_q, OPC_MOD)) begin
          state_d = (mem_rdata == '0) ? ST_IDLE : ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PRINT: state_d = ST_IDLE;
      ST_MUL:   if (cnt_q == CW'(WORD_BITS - 1)) state_d = ST_IDLE;
      ST_DIV:   if (cnt_q == CW'(WORD_BITS - 1)) state_d = ST_DFIN;
      ST_DFIN:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory port control
  always_comb begin
    logic [4:0]    r5;
    logic [3:0]    rr;
    logic [DW-1:0] ss;
    logic          qb;
    logic [W:0]    rn;
    logic [W-1:0]  fin;
    logic          neg;

    status_d  = status_q;
    pc_d      = pc_q;
    clr_d     = clr_q;
    acc_d     = acc_q;
    dec_d     = dec_q;
    u_d       = u_q;
    x_d       = x_q;
    opnd_d    = opnd_q;
    op_d      = op_q;
    dv_d      = dv_q;
    rd_d      = rd_q;
    cnt_d     = cnt_q;
    ar_a_d    = ar_a_q;
    ar_b_d    = ar_b_q;
    ar_r_d    = ar_r_q;
    negq_d    = negq_q;
    negr_d    = negr_q;
    addr_ok_d = addr_ok_q;
    rv_d      = rv_q;
    done_d    = 1'b0;
    kind_d    = KIND_NONE;
    val_d     = '0;
    used_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pc_q;
    mem_wdata = '0;
    mem_raddr = pc_q;

    // one 8-bit slice of the divide by ten, remainder kept below ten
    rr = rd_q;
    ss = dv_q;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      r5 = {rr, ss[DW-1]};
      qb = (r5 >= 5'd10);
      if (qb) r5 = r5 - 5'd10;
      rr = r5[3:0];
      ss = {ss[DW-2:0], qb};
    end

    rn = {ar_r_q[W-1:0], ar_a_q[W-1]};
    fin = '0;
    neg = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        mem_raddr = (opcode_i == CMD_READ) ? AW'(addr_i) : pc_q;
        if (accept) begin
          addr_ok_d = in_mem(64'(addr_i));
          rv_d      = read_value_i;
          unique case (opcode_i)
            CMD_WRITE: begin
              mem_we    = in_mem(64'(addr_i));
              mem_waddr = AW'(addr_i);
              mem_wdata = W'($signed(data_i));
              done_d    = 1'b1;
            end
            CMD_READ: ;
            CMD_START: begin
              pc_d     = '0;
              acc_d    = '0;
              status_d = STAT_RUN;
              done_d   = 1'b1;
            end
            CMD_STEP: begin
              if (status_q == STAT_RUN) begin
                pc_d = pc_inc;
              end else begin
                done_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        done_d = 1'b1;
        kind_d = KIND_READ;
        val_d  = addr_ok_q ? 32'(mem_rdata) : '0;
      end
      ST_FETCH: begin
        opnd_d = '0;
        if ($signed(mem_rdata) > $signed(W'(OP_LIMIT))) begin
          u_d = mem_rdata;
          x_d = W'(1);
        end else begin
          op_d = mem_rdata;
        end
      end
      ST_DCHK: begin
        if (u_q > W'(OP_LIMIT)) begin
          dv_d  = DW'(u_q);
          rd_d  = '0;
          cnt_d = '0;
        end else begin
          op_d = u_q;
        end
      end
      ST_DDIV: begin
        dv_d  = ss;
        rd_d  = rr;
        cnt_d = cnt_q + 1'b1;
      end
      ST_DACC: begin
        // fold the stripped digit into the operand, advance the place value
        u_d    = W'(dv_q);
        opnd_d = opnd_q + W'(x_q * rd_q);
        x_d    = (x_q << 3) + (x_q << 1);
      end
      ST_EXEC: begin
        dec_d     = 32'($signed(op_q));
        mem_raddr = AW'(opnd_q);
        mem_waddr = AW'(opnd_q);
        if (uses_operand(op_q) && !in_mem(64'(opnd_q))) begin
          status_d = STAT_BADADDR;
          done_d   = 1'b1;
        end else if (!reads_operand(op_q)) begin
          done_d = 1'b1;
          priority if (is_op(op_q, OPC_READ)) begin
            mem_we    = 1'b1;
            mem_wdata = W'($signed(rv_q));
            used_d    = 1'b1;
          end else if (is_op(op_q, OPC_STORE)) begin
            mem_we    = 1'b1;
            mem_wdata = acc_q;
          end else if (is_op(op_q, OPC_BRANCH)) begin
            pc_d = AW'(opnd_q);
          end else if (is_op(op_q, OPC_BRNEG)) begin
            if (acc_q[W-1]) pc_d = AW'(opnd_q);
          end else if (is_op(op_q, OPC_BRZERO)) begin
            if (acc_q == '0) pc_d = AW'(opnd_q);
          end else if (is_op(op_q, OPC_HALT)) begin
            status_d = STAT_HALT;
          end else if (is_op(op_q, OPC_DEBUG)) begin
            status_d = STAT_DEBUG;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_OPRD: begin
        mem_raddr = AW'(mem_rdata);
        cnt_d     = '0;
        ar_r_d    = '0;
        priority if (is_op(op_q, OPC_WRITE)) begin
          done_d = 1'b1;
          kind_d = KIND_NUM;
          val_d  = 32'(mem_rdata);
        end else if (is_op(op_q, OPC_PRINT)) begin
          if (!in_mem(64'(mem_rdata))) begin
            status_d = STAT_BADADDR;
            done_d   = 1'b1;
          end
        end else if (is_op(op_q, OPC_LOAD)) begin
          acc_d  = mem_rdata;
          done_d = 1'b1;
        end else if (is_op(op_q, OPC_ADD)) begin
          acc_d  = acc_q + mem_rdata;
          done_d = 1'b1;
        end else if (is_op(op_q, OPC_SUB)) begin
          acc_d  = acc_q - mem_rdata;
          done_d = 1'b1;
        end else if (is_op(op_q, OPC_MUL)) begin
          ar_a_d = acc_q;
          ar_b_d = mem_rdata;
        end else begin
          // divide or modulo on magnitudes, signs applied at the end
          if (mem_rdata == '0) begin
            status_d = STAT_DIVZERO;
            done_d   = 1'b1;
          end
          ar_a_d = acc_q[W-1] ? -acc_q : acc_q;
          ar_b_d = mem_rdata[W-1] ? -mem_rdata : mem_rdata;
          negq_d = acc_q[W-1] ^ mem_rdata[W-1];
          negr_d = acc_q[W-1];
        end
      end
      ST_PRINT: begin
        done_d = 1'b1;
        kind_d = KIND_CHAR;
        val_d  = 32'(mem_rdata[7:0]);
      end
      ST_MUL: begin
        ar_r_d = ar_r_q + (ar_b_q[0] ? {1'b0, ar_a_q} : '0);
        ar_a_d = ar_a_q << 1;
        ar_b_d = ar_b_q >> 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(WORD_BITS - 1)) begin
          acc_d  = ar_r_d[W-1:0];
          done_d = 1'b1;
        end
      end
      ST_DIV: begin
        qb = (rn >= {1'b0, ar_b_q});
        ar_r_d = qb ? rn - {1'b0, ar_b_q} : rn;
        ar_a_d = {ar_a_q[W-2:0], qb};
        cnt_d  = cnt_q + 1'b1;
      end
      ST_DFIN: begin
        if (is_op(op_q, OPC_DIV)) begin
          fin = ar_a_q;
          neg = negq_q;
        end else begin
          fin = ar_r_q[W-1:0];
          neg = negr_q;
        end
        acc_d  = neg ? -fin : fin;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      status_q <= STAT_IDLE;
      pc_q     <= '0;
      clr_q    <= '0;
      acc_q    <= '0;
      dec_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      pc_q     <= pc_d;
      clr_q    <= clr_d;
      acc_q    <= acc_d;
      dec_q    <= dec_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q       <= u_d;
    x_q       <= x_d;
    opnd_q    <= opnd_d;
    op_q      <= op_d;
    dv_q      <= dv_d;
    rd_q      <= rd_d;
    ar_a_q    <= ar_a_d;
    ar_b_q    <= ar_b_d;
    ar_r_q    <= ar_r_d;
    negq_q    <= negq_d;
    negr_q    <= negr_d;
    addr_ok_q <= addr_ok_d;
    rv_q      <= rv_d;
    kind_q    <= kind_d;
    val_q     <= val_d;
    used_q    <= used_d;
  end

  assign done_o       = done_q;
  assign out_kind_o   = kind_q;
  assign out_value_o  = val_q;
  assign status_o     = status_q;
  assign pc_o         = 10'(pc_q);
  assign acc_value_o  = 32'(acc_q);
  assign decoded_op_o = dec_q;
  assign read_used_o  = used_q;

endmodule

// ===== rtl/core/ams_checker.sv =====
module ams_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  out_kind_o,
  input logic [31:0] out_value_o,
  input logic        read_used_o
);
  import ams_pkg::*;

  // a result closes its transaction, so the block is free in that cycle
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_char_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_kind_o == KIND_CHAR) |-> (out_value_o[31:8] == '0))
    else $error("print result wider than a byte");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_kind_o == KIND_NONE) |-> (out_value_o == '0))
    else $error("value on a result without output");

  a_read_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && read_used_o) |-> (out_kind_o == KIND_NONE))
    else $error("read instruction produced output");

  // with no transaction taken, stay free and show no result
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> (!busy && !done_o))
    else $error("unexpected result");

endmodule

bind accumulator_machine_step ams_checker u_ams_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .out_kind_o (out_kind_o),
  .out_value_o(out_value_o),
  .read_used_o(read_used_o)
);
